/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the threshold fraction core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must never hold, checked outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* rtl/rtf_pkg.sv */
// ----------------------------------------------------------------------------
// rtf_pkg
// Widths, constants, scale table and shared types of the threshold fraction
// core.
// ----------------------------------------------------------------------------
package rtf_pkg;

  localparam int unsigned POT_W    = 10;
  localparam int unsigned ALT_W    = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // altitude in half metres: 2*centre + length
  localparam int unsigned A2_W     = 18;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned ROM_SIZE = 64;
  localparam int unsigned STEP_W   = 10;

  localparam int unsigned STEP_HALF_M     = 1000;
  localparam int unsigned HALF_STEP       = 500;
  localparam int unsigned GRID_POINTS_DEF = 41;

  // a2 / 1000 as (a2 * M) >> SH, exact for a2 below 2^18
  localparam int unsigned DIV_A_M_W = 18;
  localparam logic [DIV_A_M_W-1:0] DIV_A_M = 18'd134218;
  localparam int unsigned DIV_A_SH  = 27;

  // interpolation term / 1000, exact for terms below 2^26
  localparam int unsigned TERM_W    = 26;
  localparam int unsigned DIV_B_M_W = 28;
  localparam logic [DIV_B_M_W-1:0] DIV_B_M = 28'd137438954;
  localparam int unsigned DIV_B_SH  = 37;

  // fraction = pot * scale * 16000 / (284 * len)
  localparam int unsigned NUM_W  = POT_W + SCALE_W;
  localparam int unsigned DEN_W  = 25;
  localparam int unsigned REM_W  = 40;
  localparam int unsigned CMP_W  = DEN_W + FRAC_W;
  localparam logic [8:0]  THRESH_MV_PER_KM = 9'd284;
  localparam logic [13:0] FRAC_MUL = 14'd16000;
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ALT_HIGH = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_t;

  // density scale, Q4.12, 500 m grid; flat above 20 km
  localparam logic [SCALE_W-1:0] SCALE_ROM [ROM_SIZE] = '{
    4096, 4339, 4593, 4851, 5116, 5396, 5687, 5995, 6322, 6670,
    7045, 7448, 7886, 8363, 8883, 9452, 10078, 10766, 11524, 12364,
    13293, 14323, 15459, 16712, 18081, 19586, 21220, 22993, 24912, 26989,
    29219, 31623, 34195, 36963, 39949, 43179, 46689, 50484, 54619, 59110,
    64012, 64012, 64012, 64012, 64012, 64012, 64012, 64012, 64012, 64012,
    64012, 64012, 64012, 64012, 64012, 64012, 64012, 64012, 64012, 64012,
    64012, 64012, 64012, 64012
  };

  // interpolator to divider
  typedef struct packed {
    logic [POT_W-1:0]   pot;
    logic [LEN_W-1:0]   len;
    logic [SCALE_W-1:0] scale;
    status_t            status;
  } scl_t;

  // divider to output stage
  typedef struct packed {
    logic [FRAC_W-1:0]  q;
    logic               sat;
    logic [SCALE_W-1:0] scale;
    status_t            status;
  } quo_t;

endpackage

/* rtl/rtf_in_if.sv */
// ----------------------------------------------------------------------------
// rtf_in_if
// Valid/ready channel carrying one field region description.
// ----------------------------------------------------------------------------
interface rtf_in_if import rtf_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [POT_W-1:0] potential;
  logic [ALT_W-1:0] center_alt_m;
  logic [LEN_W-1:0] region_len_m;

  modport source (output valid, output potential, output center_alt_m,
                  output region_len_m, input ready);
  modport sink   (input valid, input potential, input center_alt_m,
                  input region_len_m, output ready);

endinterface

/* rtl/rtf_out_if.sv */
// ----------------------------------------------------------------------------
// rtf_out_if
// Valid/ready channel carrying one threshold fraction result.
// ----------------------------------------------------------------------------
interface rtf_out_if import rtf_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [FRAC_W-1:0]   fraction_q16;
  logic [SCALE_W-1:0]  scale_q12;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output fraction_q16, output scale_q12,
                  output status, input ready);
  modport sink   (input valid, input fraction_q16, input scale_q12,
                  input status, output ready);

endinterface

/* rtl/rtf_scale.sv */
// ----------------------------------------------------------------------------
// rtf_scale
// Seven-stage interpolator: evaluation altitude, range checks, grid index,
// table lookup and linear interpolation of the density scale.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtf_scale import rtf_pkg::*; #(
  parameter int unsigned GRID_POINTS = GRID_POINTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rtf_in_if.sink   sample,
  output logic     item_valid,
  input  logic     item_ready,
  output scl_t     item
);

  localparam int unsigned NSTG = 7;
  localparam int unsigned P_W  = TERM_W + DIV_B_M_W;
  localparam logic [A2_W-1:0] TOP_A2 = A2_W'(STEP_HALF_M * (GRID_POINTS - 1));

  typedef struct packed {
    logic [POT_W-1:0] pot;
    logic [LEN_W-1:0] len;
    status_t          status;
  } tag_t;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   en;

  // a stage loads when empty or when its content moves on
  always_comb begin
    en[NSTG] = item_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= sample.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign sample.ready = en[0];
  assign item_valid   = vld[NSTG-1];

  // stage 0: altitude in half metres and range checks
  logic [A2_W-1:0] a2_w, a2_0, a2_1;
  status_t         st_w;
  tag_t            tag0, tag1, tag2, tag3, tag4, tag5;

  always_comb begin
    a2_w = (A2_W'(sample.center_alt_m) << 1) + A2_W'(sample.region_len_m);
    priority if (a2_w > TOP_A2) begin
      st_w = ST_ALT_HIGH;
    end else if (sample.region_len_m == '0) begin
      st_w = ST_ZERO_LEN;
    end else begin
      st_w = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a2_0 <= a2_w;
      tag0 <= '{pot: sample.potential, len: sample.region_len_m, status: st_w};
    end
  end

  // stage 1: reciprocal product for the grid index
  logic [A2_W+DIV_A_M_W-1:0] prod_1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_1 <= (A2_W + DIV_A_M_W)'(a2_0) * (A2_W + DIV_A_M_W)'(DIV_A_M);
      a2_1   <= a2_0;
      tag1   <= tag0;
    end
  end

  // stage 2: index and offset within the step
  logic [IDX_W-1:0]  idx_w, idx_2;
  logic [STEP_W-1:0] frac_w, frac_2, frac_3;

  always_comb begin
    idx_w  = prod_1[DIV_A_SH +: IDX_W];
    frac_w = STEP_W'(a2_1 - A2_W'(idx_w) * A2_W'(STEP_HALF_M));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      idx_2  <= idx_w;
      frac_2 <= frac_w;
      tag2   <= tag1;
    end
  end

  // stage 3: table lookup of both neighbors
  logic [SCALE_W-1:0] y0_w, y1_w, y0_3, y0_4, y0_5, diff_3;

  always_comb begin
    y0_w = SCALE_ROM[idx_2];
    y1_w = SCALE_ROM[IDX_W'(idx_2 + 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      y0_3   <= y0_w;
      diff_3 <= y1_w - y0_w;
      frac_3 <= frac_2;
      tag3   <= tag2;
    end
  end

  // stage 4: slope times offset, plus half a step for rounding
  logic [TERM_W-1:0] t_4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t_4  <= TERM_W'(diff_3) * TERM_W'(frac_3) + TERM_W'(HALF_STEP);
      y0_4 <= y0_3;
      tag4 <= tag3;
    end
  end

  // stage 5: reciprocal product for the step division
  logic [P_W-1:0] p_5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p_5  <= P_W'(t_4) * P_W'(DIV_B_M);
      y0_5 <= y0_4;
      tag5 <= tag4;
    end
  end

  // stage 6: final scale, dropped for rejected items
  logic [SCALE_W-1:0] scale_w;

  always_comb begin
    scale_w = SCALE_W'(y0_5 + p_5[DIV_B_SH +: SCALE_W]);
    if (tag5.status != ST_OK) scale_w = '0;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      item <= '{pot: tag5.pot, len: tag5.len, scale: scale_w, status: tag5.status};
    end
  end

  `ASSERT_IMPL(a_scale_floor, clk, rst, item_valid && item.status == ST_OK, item.scale >= SCALE_ROM[0])
  `ASSERT_IMPL(a_scale_reject_zero, clk, rst, item_valid && item.status != ST_OK, item.scale == '0)

endmodule

/* rtl/rtf_div.sv */
// ----------------------------------------------------------------------------
// rtf_div
// Numerator and denominator build-up, overflow detection and a restoring
// divider with one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtf_div import rtf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  scl_t in_item,
  output logic item_valid,
  input  logic item_ready,
  output quo_t item
);

  localparam int unsigned NSTG = 3 + FRAC_W;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [FRAC_W-1:0]  q;
    logic               sat;
    logic [SCALE_W-1:0] scale;
    status_t            status;
  } dst_t;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = item_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready   = en[0];
  assign item_valid = vld[NSTG-1];

  // stage 0: potential times scale, threshold times length
  logic [NUM_W-1:0]   num_0;
  logic [DEN_W-1:0]   den_0, den_1;
  logic [SCALE_W-1:0] sc_0, sc_1;
  status_t            st_0, st_1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_0 <= NUM_W'(in_item.pot) * NUM_W'(in_item.scale);
      den_0 <= DEN_W'(in_item.len) * DEN_W'(THRESH_MV_PER_KM);
      sc_0  <= in_item.scale;
      st_0  <= in_item.status;
    end
  end

  // stage 1: scaled numerator plus half the divisor
  logic [REM_W-1:0] numr_1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      numr_1 <= REM_W'(num_0) * REM_W'(FRAC_MUL) + REM_W'(den_0 >> 1);
      den_1  <= den_0;
      sc_1   <= sc_0;
      st_1   <= st_0;
    end
  end

  // stage 2: a quotient of 2^24 or more saturates
  dst_t stg [FRAC_W+1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      stg[0] <= '{rem: numr_1, den: den_1, q: '0,
                  sat: (CMP_W'(numr_1) >= {den_1, {FRAC_W{1'b0}}}),
                  scale: sc_1, status: st_1};
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < FRAC_W; k++) begin : g_bit
    localparam int unsigned J = FRAC_W - 1 - k;
    logic [CMP_W-1:0] dvs;
    logic             fits;
    dst_t             nxt;

    always_comb begin
      dvs  = CMP_W'(stg[k].den) << J;
      fits = CMP_W'(stg[k].rem) >= dvs;
      nxt  = stg[k];
      if (fits) begin
        nxt.rem  = REM_W'(CMP_W'(stg[k].rem) - dvs);
        nxt.q[J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[3+k]) stg[k+1] <= nxt;
    end
  end

  assign item = '{q: stg[FRAC_W].q, sat: stg[FRAC_W].sat,
                  scale: stg[FRAC_W].scale, status: stg[FRAC_W].status};

  `ASSERT_IMPL(a_den_zero_len, clk, rst, vld[0] && st_0 == ST_ZERO_LEN, den_0 == '0)
  `ASSERT_IMPL(a_rem_below_den, clk, rst, item_valid && item.status == ST_OK && !item.sat, stg[FRAC_W].rem < REM_W'(stg[FRAC_W].den))

endmodule

/* rtl/rrea_threshold_fraction_core.sv */
// ----------------------------------------------------------------------------
// rrea_threshold_fraction_core
// Field strength of a region relative to the runaway avalanche threshold.
// ----------------------------------------------------------------------------
// The core takes one region per clock while the result side keeps up and
// returns one result per region, in order. An accepted input beat passes
// through 7 stages of altitude, table lookup and interpolation, 27 stages of
// division (3 to form and range-check the operands, then one quotient bit per
// stage through the 24-bit restoring divider) and the output register, which
// presents the result. Every stage has its own valid bit and loads whenever
// it is empty or its content moves on, so empty slots are filled while the
// result side stalls and input is refused only when all 35 stages hold data.
// Altitudes above the table top or a zero length return a status code with
// zero fraction and zero scale.
`include "assert_macros.svh"

module rrea_threshold_fraction_core import rtf_pkg::*; #(
  parameter int unsigned GRID_POINTS = GRID_POINTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rtf_in_if.sink     sample,
  rtf_out_if.source  result
);

  logic scl_valid, scl_ready;
  scl_t scl_item;
  logic quo_valid, quo_ready;
  quo_t quo_item;

  rtf_scale #(
    .GRID_POINTS (GRID_POINTS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .item_valid (scl_valid),
    .item_ready (scl_ready),
    .item       (scl_item)
  );

  rtf_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (scl_valid),
    .in_ready   (scl_ready),
    .in_item    (scl_item),
    .item_valid (quo_valid),
    .item_ready (quo_ready),
    .item       (quo_item)
  );

  // output register: saturate, drop the fraction of rejected items
  logic                ovld;
  logic [FRAC_W-1:0]   ofrac, ofrac_next;
  logic [SCALE_W-1:0]  oscale;
  logic [STATUS_W-1:0] ostatus;

  assign quo_ready = !ovld || result.ready;

  always_comb begin
    priority if (quo_item.status != ST_OK) begin
      ofrac_next = '0;
    end else if (quo_item.sat) begin
      ofrac_next = FRAC_MAX;
    end else begin
      ofrac_next = quo_item.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (quo_ready) begin
      ovld <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quo_ready) begin
      ofrac   <= ofrac_next;
      oscale  <= quo_item.scale;
      ostatus <= quo_item.status;
    end
  end

  assign result.valid        = ovld;
  assign result.fraction_q16 = ofrac;
  assign result.scale_q12    = oscale;
  assign result.status       = ostatus;

  `ASSERT_IMPL(a_reject_no_fraction, clk, rst, result.valid && result.status != ST_OK, result.fraction_q16 == '0)

endmodule
